>>> rtl/core/pds_pkg.sv
package pds_pkg;

    localparam int TICKS_PER_SECOND_DEF = 4;
    localparam int TRAVEL_TICKS_DEF     = 16;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DEPLOY_INHIBIT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTUATION_GAP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_DEG        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STOW_FLIP       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPLOY_UPRIGHT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_SEP        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_STORED_DEPLOYED = 3'd6;

    localparam logic [2:0] OP_START      = 3'd0;
    localparam logic [2:0] OP_TICK       = 3'd1;
    localparam logic [2:0] OP_SEPARATION = 3'd2;
    localparam logic [2:0] OP_ABORT      = 3'd3;
    localparam logic [2:0] OP_SET_AUTO   = 3'd4;
    localparam logic [2:0] OP_MANUAL     = 3'd5;

    localparam logic [2:0] PH_BOOT      = 3'd0;
    localparam logic [2:0] PH_PRELAUNCH = 3'd1;
    localparam logic [2:0] PH_LEOP      = 3'd2;
    localparam logic [2:0] PH_DEPLOYING = 3'd3;
    localparam logic [2:0] PH_NOMINAL   = 3'd4;
    localparam logic [2:0] PH_STOWED    = 3'd5;
    localparam logic [2:0] PH_MANUAL    = 3'd6;

    localparam logic [1:0] OR_UNKNOWN  = 2'd0;
    localparam logic [1:0] OR_UPRIGHT  = 2'd1;
    localparam logic [1:0] OR_INVERTED = 2'd2;

    localparam logic [1:0] MOT_NONE  = 2'd0;
    localparam logic [1:0] MOT_OPEN  = 2'd1;
    localparam logic [1:0] MOT_CLOSE = 2'd2;

    localparam int          SEP_W          = 18;
    localparam logic [17:0] SEP_MAX        = 18'h3FFFF;
    localparam int          PHASE_TICK_W   = 5;
    localparam logic [4:0]  PHASE_TICK_MAX = 5'd31;
    localparam logic [7:0]  ANGLE_TOL      = 8'd15;

    typedef struct packed {
        logic [2:0] operation;
        logic       power_on;
        logic       auto_on;
        logic       orientation_changed;
        logic [1:0] new_orientation;
        logic       status_valid;
        logic [7:0] srv_deg;
        logic       servo_idle;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  phase;
        logic [1:0]  orientation;
        logic [1:0]  motor_command;
        logic        deployed;
        logic        confirmed;
        logic [15:0] countdown_s;
    } t_out_item;

    typedef struct packed {
        logic [15:0] inhibit_secs;
        logic [7:0]  open_deg;
        logic        stow_flip_en;
        logic        upright_redeploy_en;
        logic        auto_sep_en;
        logic        stored_deployed;
    } t_cfg;

endpackage

>>> rtl/core/pds_cfg.sv
module pds_cfg import pds_pkg::*; #(
    parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEF,
    parameter int GAP_W = 16 + $clog2(TICKS_PER_SECOND)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg,
    output logic [GAP_W-1:0]      o_gap_ticks
);

    t_cfg             r_cfg;
    logic [GAP_W-1:0] r_gap_ticks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= '0;
            r_gap_ticks <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DEPLOY_INHIBIT:  r_cfg.inhibit_secs  <= i_cfg_data;
                CFG_ACTUATION_GAP:   r_gap_ticks <= GAP_W'(i_cfg_data) *
                                                    GAP_W'(TICKS_PER_SECOND);
                CFG_OPEN_DEG:        r_cfg.open_deg      <= i_cfg_data[7:0];
                CFG_STOW_FLIP:       r_cfg.stow_flip_en  <= i_cfg_data[0];
                CFG_DEPLOY_UPRIGHT:  r_cfg.upright_redeploy_en <= i_cfg_data[0];
                CFG_AUTO_SEP:        r_cfg.auto_sep_en     <= i_cfg_data[0];
                CFG_STORED_DEPLOYED: r_cfg.stored_deployed <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg       = r_cfg;
    assign o_gap_ticks = r_gap_ticks;

endmodule

>>> rtl/core/pds_core.sv
module pds_core import pds_pkg::*; #(
    parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEF,
    parameter int TRAVEL_TICKS = TRAVEL_TICKS_DEF,
    parameter int GAP_W = 16 + $clog2(TICKS_PER_SECOND)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  t_in_item         i_item,
    input  t_cfg             i_cfg,
    input  logic [GAP_W-1:0] i_gap_ticks,
    output t_out_item        o_result
);

    localparam int FRAC_W = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
    localparam int CMP_W  = (GAP_W > SEP_W) ? GAP_W : SEP_W;

    logic [2:0]              r_phase, n_phase;
    logic                    r_armed, n_armed;
    logic [1:0]              r_orient, n_orient;
    logic                    r_deployed, n_deployed;
    logic                    r_confirmed, n_confirmed;
    logic [PHASE_TICK_W-1:0] r_tip, n_tip;
    logic [SEP_W-1:0]        r_tss, n_tss;
    logic [FRAC_W-1:0]       r_sep_frac, n_sep_frac;
    logic [SEP_W-1:0]        r_sep_sec, n_sep_sec;
    logic [SEP_W-1:0]        r_tsa, n_tsa;
    logic                    r_ever, n_ever;
    logic [1:0]              motor;
    logic                    gap_ok;
    logic                    cd_zero_now;
    logic [7:0]              angle_err;
    logic [15:0]             countdown;

    always_comb begin
        n_phase     = r_phase;
        n_armed     = r_armed;
        n_orient    = r_orient;
        n_deployed  = r_deployed;
        n_confirmed = r_confirmed;
        n_tip       = r_tip;
        n_tss       = r_tss;
        n_sep_frac  = r_sep_frac;
        n_sep_sec   = r_sep_sec;
        n_tsa       = r_tsa;
        n_ever      = r_ever;
        motor       = MOT_NONE;

        gap_ok = !r_ever || (r_tsa >= SEP_MAX) ||
                 (CMP_W'(r_tsa) >= CMP_W'(i_gap_ticks));
        cd_zero_now = (r_tss >= SEP_MAX) ||
                      (r_sep_sec >= SEP_W'(i_cfg.inhibit_secs));
        angle_err = (i_item.srv_deg >= i_cfg.open_deg) ?
                    i_item.srv_deg - i_cfg.open_deg :
                    i_cfg.open_deg - i_item.srv_deg;

        unique case (i_item.operation)
            OP_START: begin
                n_deployed = i_cfg.stored_deployed;
                if (i_item.power_on && i_cfg.auto_sep_en) begin
                    n_tss      = '0;
                    n_sep_frac = '0;
                    n_sep_sec  = '0;
                    if (n_phase != PH_LEOP) n_tip = '0;
                    n_phase = PH_LEOP;
                end else begin
                    if (n_phase != (n_deployed ? PH_NOMINAL : PH_PRELAUNCH)) n_tip = '0;
                    n_phase = n_deployed ? PH_NOMINAL : PH_PRELAUNCH;
                end
            end
            OP_TICK: begin
                if (i_item.orientation_changed) begin
                    n_orient = i_item.new_orientation;
                    if (r_armed && gap_ok) begin
                        if (n_orient == OR_INVERTED && i_cfg.stow_flip_en &&
                            (r_phase == PH_NOMINAL || r_phase == PH_LEOP)) begin
                            n_tsa      = '0;
                            n_ever     = 1'b1;
                            n_deployed = 1'b0;
                            n_tip      = '0;
                            n_phase    = PH_STOWED;
                            motor      = MOT_CLOSE;
                        end else if (n_orient == OR_UPRIGHT && i_cfg.upright_redeploy_en &&
                                     r_phase == PH_STOWED) begin
                            n_tsa   = '0;
                            n_ever  = 1'b1;
                            n_tip   = '0;
                            n_phase = PH_DEPLOYING;
                            motor   = MOT_OPEN;
                        end
                    end
                end
                if (n_phase == PH_LEOP) begin
                    if (cd_zero_now) begin
                        n_tsa   = '0;
                        n_ever  = 1'b1;
                        n_tip   = '0;
                        n_phase = PH_DEPLOYING;
                        motor   = MOT_OPEN;
                    end
                end else if (n_phase == PH_DEPLOYING) begin
                    if (n_tip >= PHASE_TICK_W'(TRAVEL_TICKS)) begin
                        n_confirmed = i_item.status_valid && i_item.servo_idle &&
                                      (angle_err <= ANGLE_TOL);
                        n_deployed  = 1'b1;
                        n_tip       = '0;
                        n_phase     = PH_NOMINAL;
                    end
                end
                if (n_tip < PHASE_TICK_MAX) n_tip = n_tip + 1'b1;
                if (n_tss < SEP_MAX) begin
                    n_tss = n_tss + 1'b1;
                    if (n_sep_frac == FRAC_W'(TICKS_PER_SECOND - 1)) begin
                        n_sep_frac = '0;
                        n_sep_sec  = n_sep_sec + 1'b1;
                    end else begin
                        n_sep_frac = n_sep_frac + 1'b1;
                    end
                end
                if (n_tsa < SEP_MAX) n_tsa = n_tsa + 1'b1;
            end
            OP_SEPARATION: begin
                n_tss      = '0;
                n_sep_frac = '0;
                n_sep_sec  = '0;
                if (n_phase != PH_LEOP) n_tip = '0;
                n_phase = PH_LEOP;
            end
            OP_ABORT: begin
                if (r_phase == PH_LEOP) begin
                    n_tip   = '0;
                    n_phase = r_deployed ? PH_NOMINAL : PH_PRELAUNCH;
                end
            end
            OP_SET_AUTO: begin
                n_armed = i_item.auto_on;
                if (i_item.auto_on && r_phase == PH_MANUAL) begin
                    n_tip   = '0;
                    n_phase = r_deployed ? PH_NOMINAL : PH_STOWED;
                end
            end
            OP_MANUAL: begin
                n_tsa  = '0;
                n_ever = 1'b1;
                if (n_phase != PH_MANUAL) n_tip = '0;
                n_phase = PH_MANUAL;
            end
            default: ;
        endcase

        if (n_phase != PH_LEOP || n_tss >= SEP_MAX ||
            n_sep_sec >= SEP_W'(i_cfg.inhibit_secs)) begin
            countdown = '0;
        end else begin
            countdown = i_cfg.inhibit_secs - n_sep_sec[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_BOOT;
            r_armed     <= 1'b1;
            r_orient    <= OR_UNKNOWN;
            r_deployed  <= 1'b0;
            r_confirmed <= 1'b0;
            r_tip       <= '0;
            r_tss       <= '0;
            r_sep_frac  <= '0;
            r_sep_sec   <= '0;
            r_tsa       <= '0;
            r_ever      <= 1'b0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_armed     <= n_armed;
            r_orient    <= n_orient;
            r_deployed  <= n_deployed;
            r_confirmed <= n_confirmed;
            r_tip       <= n_tip;
            r_tss       <= n_tss;
            r_sep_frac  <= n_sep_frac;
            r_sep_sec   <= n_sep_sec;
            r_tsa       <= n_tsa;
            r_ever      <= n_ever;
        end
    end

    assign o_result.phase         = n_phase;
    assign o_result.orientation   = n_orient;
    assign o_result.motor_command = motor;
    assign o_result.deployed      = n_deployed;
    assign o_result.confirmed     = n_confirmed;
    assign o_result.countdown_s   = countdown;

endmodule

>>> rtl/core/panel_deploy_phase_sequencer.sv
// Channel   Direction  Signals                                  Beat
// input     in         i_in_valid, o_in_stall, i_in_data        one event
// output    out        o_out_valid, i_out_stall, o_out_data     one result per event
// config    in         i_cfg_we, i_cfg_index, i_cfg_data        one register write
//
// An accepted event sits in the input register until the output register is free, and its
// result is then loaded into the output register.
// One beat is taken every cycle while the output is not stalled; the rate is set by the single state update stage.
// Reset is synchronous and active low and restores the boot phase and default registers.
// A stall on the output holds the result, and the input stalls only while an event
// waits in the input register behind a stalled result.
module panel_deploy_phase_sequencer import pds_pkg::*; #(
    parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEF,
    parameter int TRAVEL_TICKS = TRAVEL_TICKS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int GAP_W = 16 + $clog2(TICKS_PER_SECOND);

    logic             r_in_valid;
    t_in_item         r_in;
    logic             r_out_valid;
    t_out_item        r_out;
    logic             out_free;
    logic             step;
    t_cfg             cfg;
    logic [GAP_W-1:0] gap_ticks;
    t_out_item        result;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) r_in_valid <= i_in_valid;
            if (out_free) r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) r_in <= i_in_data;
        if (step) r_out <= result;
    end

    pds_cfg #(
        .TICKS_PER_SECOND(TICKS_PER_SECOND),
        .GAP_W(GAP_W)
    ) u_cfg (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .o_cfg(cfg),
        .o_gap_ticks(gap_ticks)
    );

    pds_core #(
        .TICKS_PER_SECOND(TICKS_PER_SECOND),
        .TRAVEL_TICKS(TRAVEL_TICKS),
        .GAP_W(GAP_W)
    ) u_core (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_step(step),
        .i_item(r_in),
        .i_cfg(cfg),
        .i_gap_ticks(gap_ticks),
        .o_result(result)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> rtl/core/pds_checker.sv
module pds_checker import pds_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input t_in_item              i_in_data,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input t_out_item             o_out_data,
    input logic                  i_cfg_we,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result beat changed");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a stalled result");

    a_open_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.motor_command == MOT_OPEN
        |-> o_out_data.phase == PH_DEPLOYING)
        else $error("open command outside deploying phase");

    a_close_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.motor_command == MOT_CLOSE
        |-> o_out_data.phase == PH_STOWED && !o_out_data.deployed)
        else $error("close command without stowing");

    a_countdown_leop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.countdown_s != 16'd0
        |-> o_out_data.phase == PH_LEOP)
        else $error("countdown reported outside leop");

endmodule

bind panel_deploy_phase_sequencer pds_checker u_pds_checker (.*);
